// ===== sv/linear_interp_rate_converter_defines.svh =====
// Assertion macros shared by the rate converter RTL.
// Macros expect signals named clock and reset in the including scope.
`ifndef LINEAR_INTERP_RATE_CONVERTER_DEFINES_SVH
`define LINEAR_INTERP_RATE_CONVERTER_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define LIRC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lirc same-cycle check failed");

// Next-cycle implication, masked during reset.
`define LIRC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lirc next-cycle check failed");

`endif

// ===== sv/lirc_pkg.sv =====
// Shared types and constants for the linear interpolation rate converter.
// No dependencies; used by the channel interfaces and the top level.
package lirc_pkg;

   // Field and datapath widths
   localparam int SAMPLE_BITS    = 16;
   localparam int RATE_BITS      = 16;
   localparam int STATUS_BITS    = 2;
   localparam int CHAN_BITS      = 2;
   localparam int POS_BITS       = 33;
   localparam int PROD_BITS      = 2 * RATE_BITS;
   localparam int MAX_CHANNELS   = 2;
   localparam int NUM_LANES      = 2;
   localparam int GCD_SHIFT_BITS = $clog2(RATE_BITS);

   // Result limit per request
   localparam int RESULT_LIMIT = 64;
   localparam int LIMIT_SHIFT  = $clog2(RESULT_LIMIT);
   localparam int COUNT_BITS   = LIMIT_SHIFT + 1;

   // Serial unit step counts
   localparam int DIV_STEPS = POS_BITS;
   localparam int MUL_STEPS = RATE_BITS;
   localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);

   // CSR port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = RATE_BITS;

   typedef logic [POS_BITS-1:0]    pos_type;
   typedef logic [PROD_BITS-1:0]   prod_type;
   typedef logic [RATE_BITS-1:0]   rate_type;
   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [CNT_BITS-1:0]    cnt_type;

   localparam logic [CSR_INDEX_BITS-1:0] REG_INPUT_RATE      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OUTPUT_RATE     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ACTIVE_CHANNELS = 2'd2;

   localparam rate_type               INPUT_RATE_RESET  = 16'd360;
   localparam rate_type               OUTPUT_RATE_RESET = 16'd360;
   localparam logic [CHAN_BITS-1:0]   ACTIVE_CH_RESET   = 2'd2;
   localparam rate_type               RATE_ONE          = 16'd1;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_START  = 1'b1;

   localparam count_type RESULT_LIMIT_C = COUNT_BITS'(RESULT_LIMIT);
   localparam count_type RESULT_LAST_C  = COUNT_BITS'(RESULT_LIMIT - 1);
   localparam cnt_type   DIV_LAST_C     = CNT_BITS'(DIV_STEPS);
   localparam cnt_type   MUL_LAST_C     = CNT_BITS'(MUL_STEPS);

   typedef struct packed {
      logic                          command;
      logic signed [SAMPLE_BITS-1:0] chan0_sample;
      logic signed [SAMPLE_BITS-1:0] chan1_sample;
      logic [STATUS_BITS-1:0]        input_status;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] chan0_value;
      logic signed [SAMPLE_BITS-1:0] chan1_value;
      logic [STATUS_BITS-1:0]        stream_status;
      logic                          last;
      logic                          dropped;
   } rsp_type;

endpackage

// ===== sv/lirc_req_if.sv =====
// Request channel: valid/ready handshake carrying one lirc_pkg::req_type.
// Depends on lirc_pkg.
interface lirc_req_if;
   logic             valid;
   logic             ready;
   lirc_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/lirc_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one lirc_pkg::rsp_type.
// Depends on lirc_pkg.
interface lirc_rsp_if;
   logic             valid;
   logic             ready;
   lirc_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/linear_interp_rate_converter.sv =====
// Top level of the linear interpolation sample-rate converter (two channels).
// Depends on lirc_pkg, lirc_req_if, lirc_rsp_if and the assertion macro header.
//
//   Channel    Dir  Handshake      Carries
//   req_chan   in   valid/ready    command, two samples, status
//   rsp_chan   out  valid/ready    two interpolated values, status, last, dropped
//   csr_*      in   write enable   input_rate, output_rate, active_channels
//
// A start request runs a binary gcd, three serial divisions and a serial multiply.
// The first vector after start is only stored, the second goes to the prep state and
// later ones pass through the wrap and advance states first; each result then takes,
// per lane, a serial multiply and a serial divide on shared units.
// An item with more than 64 results adds two serial divisions.
// Reset is synchronous; no clearing pass. A full result register stalls only the
// sequencer, and a new request is taken only once the sequencer is back in idle.
`include "linear_interp_rate_converter_defines.svh"

module linear_interp_rate_converter (
   input  logic                                  clock,
   input  logic                                  reset,
   lirc_req_if.sink                              req_chan,
   lirc_rsp_if.source                            rsp_chan,
   input  logic                                  csr_write_en,
   input  logic [lirc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lirc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   // Sequencer states
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_GCD      = 4'd1;
   localparam logic [3:0] ST_RED_M    = 4'd2;
   localparam logic [3:0] ST_RED_N    = 4'd3;
   localparam logic [3:0] ST_MODMN    = 4'd4;
   localparam logic [3:0] ST_SPAN     = 4'd5;
   localparam logic [3:0] ST_WRAP     = 4'd6;
   localparam logic [3:0] ST_ADV      = 4'd7;
   localparam logic [3:0] ST_PREP     = 4'd8;
   localparam logic [3:0] ST_CHECK    = 4'd9;
   localparam logic [3:0] ST_MUL      = 4'd10;
   localparam logic [3:0] ST_IDIV     = 4'd11;
   localparam logic [3:0] ST_EMIT     = 4'd12;
   localparam logic [3:0] ST_SKIP_DIV = 4'd13;
   localparam logic [3:0] ST_FRAC_DIV = 4'd14;

   // Pair fill levels
   localparam logic [1:0] PRIMED_NONE = 2'd0;
   localparam logic [1:0] PRIMED_HALF = 2'd1;
   localparam logic [1:0] PRIMED_FULL = 2'd2;

   localparam int SB           = lirc_pkg::SAMPLE_BITS;
   localparam int RATE_BITS_P1 = lirc_pkg::RATE_BITS + 1;

   // Configuration registers
   lirc_pkg::rate_type                in_rate_ff, in_rate_in;
   lirc_pkg::rate_type                out_rate_ff, out_rate_in;
   logic [lirc_pkg::CHAN_BITS-1:0]    act_ff, act_in;

   // Sequencer and converter state
   logic [3:0]                        state_ff, state_in;
   lirc_pkg::cnt_type                 cnt_ff, cnt_in;
   logic [1:0]                        primed_ff, primed_in;
   lirc_pkg::rate_type                n_ff, n_in;
   lirc_pkg::rate_type                m_ff, m_in;
   lirc_pkg::rate_type                mmodn_ff, mmodn_in;
   lirc_pkg::rate_type                frac_ff, frac_in;
   lirc_pkg::prod_type                span_ff, span_in;
   lirc_pkg::pos_type                 in_pos_ff, in_pos_in;
   lirc_pkg::pos_type                 out_pos_ff, out_pos_in;
   lirc_pkg::count_type               count_ff, count_in;
   logic                              lost_ff, lost_in;
   logic                              lane_ff, lane_in;
   logic                              neg_ff, neg_in;
   logic [lirc_pkg::STATUS_BITS-1:0]  status_ff, status_in;
   lirc_pkg::sample_type              prev_ff [lirc_pkg::NUM_LANES];
   lirc_pkg::sample_type              prev_in [lirc_pkg::NUM_LANES];
   lirc_pkg::sample_type              cur_ff  [lirc_pkg::NUM_LANES];
   lirc_pkg::sample_type              cur_in  [lirc_pkg::NUM_LANES];
   lirc_pkg::sample_type              val_ff  [lirc_pkg::NUM_LANES];
   lirc_pkg::sample_type              val_in  [lirc_pkg::NUM_LANES];

   // GCD registers
   lirc_pkg::rate_type                ga_ff, ga_in;
   lirc_pkg::rate_type                gb_ff, gb_in;
   logic [lirc_pkg::GCD_SHIFT_BITS-1:0] gk_ff, gk_in;

   // Serial divider: dividend/quotient shift register, remainder, divisor
   lirc_pkg::pos_type                 dvd_ff, dvd_in;
   lirc_pkg::rate_type                rem_ff, rem_in;
   lirc_pkg::rate_type                dsr_ff, dsr_in;

   // Serial multiplier: shifting multiplicand, shifting multiplier, accumulator
   lirc_pkg::prod_type                mca_ff, mca_in;
   lirc_pkg::rate_type                mcb_ff, mcb_in;
   lirc_pkg::prod_type                acc_ff, acc_in;

   // Result register
   logic                              rsp_valid_ff, rsp_valid_in;
   lirc_pkg::rsp_type                 rsp_word_ff, rsp_word_in;

   // Combinational helpers
   logic                              rsp_load;
   logic [RATE_BITS_P1-1:0]           div_trial;
   logic [RATE_BITS_P1:0]             div_diff;
   logic                              div_ge;
   lirc_pkg::rate_type                div_rem_step;
   lirc_pkg::pos_type                 div_dvd_step;
   logic                              div_done;
   lirc_pkg::prod_type                mul_acc_step;
   logic                              mul_done;
   lirc_pkg::rate_type                in_rate_nz, out_rate_nz;
   lirc_pkg::rate_type                ga_minus, gb_minus;
   lirc_pkg::pos_type                 pos_gap, m_limit, out_next, skip_target;
   logic                              out_le_in;
   logic [RATE_BITS_P1-1:0]           frac_sum, frac_wrap;
   lirc_pkg::rate_type                frac_next;
   logic [SB:0]                       lane_diff [lirc_pkg::NUM_LANES];
   logic [SB:0]                       lane_mag  [lirc_pkg::NUM_LANES];
   logic                              lane_active [lirc_pkg::NUM_LANES];
   logic [SB:0]                       q_mag, q_signed, interp_sum;
   logic                              last_bit;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_word_ff;

   // CSR writes
   always_comb begin
      in_rate_in  = in_rate_ff;
      out_rate_in = out_rate_ff;
      act_in      = act_ff;
      if (csr_write_en) begin
         case (csr_index)
            lirc_pkg::REG_INPUT_RATE:      in_rate_in  = csr_wdata;
            lirc_pkg::REG_OUTPUT_RATE:     out_rate_in = csr_wdata;
            lirc_pkg::REG_ACTIVE_CHANNELS: act_in      = csr_wdata[lirc_pkg::CHAN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Datapath helpers: one divider step, one multiplier step, position compares
   always_comb begin
      in_rate_nz  = (in_rate_ff == '0) ? lirc_pkg::RATE_ONE : in_rate_ff;
      out_rate_nz = (out_rate_ff == '0) ? lirc_pkg::RATE_ONE : out_rate_ff;
      ga_minus    = ga_ff - gb_ff;
      gb_minus    = gb_ff - ga_ff;

      div_trial    = {rem_ff, dvd_ff[lirc_pkg::POS_BITS-1]};
      div_diff     = {1'b0, div_trial} - {2'b00, dsr_ff};
      div_ge       = !div_diff[RATE_BITS_P1];
      div_rem_step = div_ge ? div_diff[lirc_pkg::RATE_BITS-1:0]
                            : div_trial[lirc_pkg::RATE_BITS-1:0];
      div_dvd_step = {dvd_ff[lirc_pkg::POS_BITS-2:0], div_ge};
      div_done     = (cnt_ff == lirc_pkg::DIV_LAST_C);

      mul_acc_step = mcb_ff[0] ? (acc_ff + mca_ff) : acc_ff;
      mul_done     = (cnt_ff == lirc_pkg::MUL_LAST_C);

      pos_gap     = in_pos_ff - out_pos_ff;
      out_le_in   = (out_pos_ff <= in_pos_ff);
      m_limit     = lirc_pkg::pos_type'(m_ff) << lirc_pkg::LIMIT_SHIFT;
      out_next    = out_pos_ff + lirc_pkg::pos_type'(m_ff);
      skip_target = in_pos_ff - lirc_pkg::pos_type'(rem_ff) + lirc_pkg::pos_type'(m_ff);

      // frac tracks out_position mod n; each step adds m mod n
      frac_sum  = {1'b0, frac_ff} + {1'b0, mmodn_ff};
      frac_wrap = frac_sum - {1'b0, n_ff};
      frac_next = (frac_sum >= {1'b0, n_ff}) ? frac_wrap[lirc_pkg::RATE_BITS-1:0]
                                             : frac_sum[lirc_pkg::RATE_BITS-1:0];

      for (int k = 0; k < lirc_pkg::NUM_LANES; k++) begin
         lane_diff[k]   = {cur_ff[k][SB-1], cur_ff[k]} - {prev_ff[k][SB-1], prev_ff[k]};
         lane_mag[k]    = lane_diff[k][SB] ? (~lane_diff[k] + 1'b1) : lane_diff[k];
         lane_active[k] = (int'(act_ff) > k) && (k < lirc_pkg::MAX_CHANNELS);
      end

      // Signed quotient, truncated toward zero, added to the older sample
      q_mag      = dvd_ff[SB:0];
      q_signed   = neg_ff ? (~q_mag + 1'b1) : q_mag;
      interp_sum = {prev_ff[lane_ff][SB-1], prev_ff[lane_ff]} + q_signed;

      last_bit = (count_ff == lirc_pkg::RESULT_LAST_C) || (out_next > in_pos_ff);
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      primed_in = primed_ff;
      n_in      = n_ff;
      m_in      = m_ff;
      mmodn_in  = mmodn_ff;
      frac_in   = frac_ff;
      span_in   = span_ff;
      in_pos_in = in_pos_ff;
      out_pos_in = out_pos_ff;
      count_in  = count_ff;
      lost_in   = lost_ff;
      lane_in   = lane_ff;
      neg_in    = neg_ff;
      status_in = status_ff;
      prev_in   = prev_ff;
      cur_in    = cur_ff;
      val_in    = val_ff;
      ga_in     = ga_ff;
      gb_in     = gb_ff;
      gk_in     = gk_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      mca_in    = mca_ff;
      mcb_in    = mcb_ff;
      acc_in    = acc_ff;
      rsp_load  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.payload.command == lirc_pkg::CMD_START) begin
                  ga_in      = in_rate_nz;
                  gb_in      = out_rate_nz;
                  gk_in      = '0;
                  in_pos_in  = '0;
                  out_pos_in = '0;
                  frac_in    = '0;
                  primed_in  = PRIMED_NONE;
                  state_in   = ST_GCD;
               end else begin
                  status_in = req_chan.payload.input_status;
                  case (primed_ff)
                     PRIMED_NONE: begin
                        prev_in[0] = req_chan.payload.chan0_sample;
                        prev_in[1] = req_chan.payload.chan1_sample;
                        primed_in  = PRIMED_HALF;
                     end
                     PRIMED_HALF: begin
                        cur_in[0] = req_chan.payload.chan0_sample;
                        cur_in[1] = req_chan.payload.chan1_sample;
                        primed_in = PRIMED_FULL;
                        state_in  = ST_PREP;
                     end
                     default: begin
                        prev_in   = cur_ff;
                        cur_in[0] = req_chan.payload.chan0_sample;
                        cur_in[1] = req_chan.payload.chan1_sample;
                        state_in  = ST_WRAP;
                     end
                  endcase
               end
            end
         end

         // Binary gcd, one shift or subtract per cycle
         ST_GCD: begin
            if (ga_ff == gb_ff) begin
               dvd_in   = lirc_pkg::pos_type'(in_rate_nz);
               dsr_in   = ga_ff << gk_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_RED_M;
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               gk_in = gk_ff + 1'b1;
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ff > gb_ff) begin
               ga_in = ga_minus >> 1;
            end else begin
               gb_in = gb_minus >> 1;
            end
         end

         // m = input_rate / g
         ST_RED_M: begin
            if (!div_done) begin
               dvd_in = div_dvd_step;
               rem_in = div_rem_step;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               m_in     = dvd_ff[lirc_pkg::RATE_BITS-1:0];
               dvd_in   = lirc_pkg::pos_type'(out_rate_nz);
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_RED_N;
            end
         end

         // n = output_rate / g
         ST_RED_N: begin
            if (!div_done) begin
               dvd_in = div_dvd_step;
               rem_in = div_rem_step;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               n_in     = dvd_ff[lirc_pkg::RATE_BITS-1:0];
               dvd_in   = lirc_pkg::pos_type'(m_ff);
               dsr_in   = dvd_ff[lirc_pkg::RATE_BITS-1:0];
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_MODMN;
            end
         end

         // m mod n for the incremental phase
         ST_MODMN: begin
            if (!div_done) begin
               dvd_in = div_dvd_step;
               rem_in = div_rem_step;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               mmodn_in = rem_ff;
               mca_in   = lirc_pkg::prod_type'(m_ff);
               mcb_in   = n_ff;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_SPAN;
            end
         end

         // span = n * m
         ST_SPAN: begin
            if (!mul_done) begin
               acc_in = mul_acc_step;
               mca_in = mca_ff << 1;
               mcb_in = mcb_ff >> 1;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               span_in  = acc_ff;
               state_in = ST_IDLE;
            end
         end

         ST_WRAP: begin
            if (in_pos_ff > lirc_pkg::pos_type'(span_ff)) begin
               in_pos_in  = in_pos_ff - lirc_pkg::pos_type'(span_ff);
               out_pos_in = out_pos_ff - lirc_pkg::pos_type'(span_ff);
            end
            state_in = ST_ADV;
         end

         ST_ADV: begin
            in_pos_in = in_pos_ff + lirc_pkg::pos_type'(n_ff);
            state_in  = ST_PREP;
         end

         // More than the limit pending when the gap reaches limit * m
         ST_PREP: begin
            lost_in  = out_le_in && (pos_gap >= m_limit);
            count_in = '0;
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            if (out_le_in && (count_ff != lirc_pkg::RESULT_LIMIT_C)) begin
               lane_in  = 1'b0;
               neg_in   = lane_diff[0][SB];
               mca_in   = lirc_pkg::prod_type'(lane_mag[0]);
               mcb_in   = frac_ff;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_MUL;
            end else if (out_le_in) begin
               dvd_in   = pos_gap;
               dsr_in   = m_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_SKIP_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end

         // frac * |cur - prev|
         ST_MUL: begin
            if (!mul_done) begin
               acc_in = mul_acc_step;
               mca_in = mca_ff << 1;
               mcb_in = mcb_ff >> 1;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               dvd_in   = lirc_pkg::pos_type'(acc_ff);
               dsr_in   = n_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_IDIV;
            end
         end

         // product / n, then on to the next lane or the result
         ST_IDIV: begin
            if (!div_done) begin
               dvd_in = div_dvd_step;
               rem_in = div_rem_step;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               val_in[lane_ff] = interp_sum[SB-1:0];
               if (!lane_ff) begin
                  lane_in  = 1'b1;
                  neg_in   = lane_diff[1][SB];
                  mca_in   = lirc_pkg::prod_type'(lane_mag[1]);
                  mcb_in   = frac_ff;
                  acc_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load   = 1'b1;
               out_pos_in = out_next;
               frac_in    = frac_next;
               count_in   = count_ff + 1'b1;
               state_in   = ST_CHECK;
            end
         end

         // Skip dropped outputs: out = in - ((in - out) mod m) + m
         ST_SKIP_DIV: begin
            if (!div_done) begin
               dvd_in = div_dvd_step;
               rem_in = div_rem_step;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               out_pos_in = skip_target;
               dvd_in     = skip_target;
               dsr_in     = n_ff;
               rem_in     = '0;
               cnt_in     = '0;
               state_in   = ST_FRAC_DIV;
            end
         end

         // Recover frac = out_position mod n after the skip
         ST_FRAC_DIV: begin
            if (!div_done) begin
               dvd_in = div_dvd_step;
               rem_in = div_rem_step;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               frac_in  = rem_ff;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Result word and its valid flag
   always_comb begin
      rsp_word_in               = rsp_word_ff;
      rsp_valid_in              = rsp_valid_ff;
      if (rsp_load) begin
         rsp_word_in.chan0_value   = lane_active[0] ? val_ff[0] : '0;
         rsp_word_in.chan1_value   = lane_active[1] ? val_ff[1] : '0;
         rsp_word_in.stream_status = status_ff;
         rsp_word_in.last          = last_bit;
         rsp_word_in.dropped       = lost_ff;
         rsp_valid_in              = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_rate_ff   <= lirc_pkg::INPUT_RATE_RESET;
         out_rate_ff  <= lirc_pkg::OUTPUT_RATE_RESET;
         act_ff       <= lirc_pkg::ACTIVE_CH_RESET;
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         primed_ff    <= PRIMED_NONE;
         n_ff         <= lirc_pkg::RATE_ONE;
         m_ff         <= lirc_pkg::RATE_ONE;
         mmodn_ff     <= '0;
         frac_ff      <= '0;
         span_ff      <= lirc_pkg::prod_type'(lirc_pkg::RATE_ONE);
         in_pos_ff    <= '0;
         out_pos_ff   <= '0;
         count_ff     <= '0;
         lost_ff      <= 1'b0;
         lane_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_rate_ff   <= in_rate_in;
         out_rate_ff  <= out_rate_in;
         act_ff       <= act_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         primed_ff    <= primed_in;
         n_ff         <= n_in;
         m_ff         <= m_in;
         mmodn_ff     <= mmodn_in;
         frac_ff      <= frac_in;
         span_ff      <= span_in;
         in_pos_ff    <= in_pos_in;
         out_pos_ff   <= out_pos_in;
         count_ff     <= count_in;
         lost_ff      <= lost_in;
         lane_ff      <= lane_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and serial-unit registers
   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      status_ff   <= status_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      val_ff      <= val_in;
      ga_ff       <= ga_in;
      gb_ff       <= gb_in;
      gk_ff       <= gk_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      dsr_ff      <= dsr_in;
      mca_ff      <= mca_in;
      mcb_ff      <= mcb_in;
      acc_ff      <= acc_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Checks
   `LIRC_ASSERT_NOW(a_frac_below_n, 1'b1, frac_ff < n_ff)
   `LIRC_ASSERT_NOW(a_gcd_operands_nonzero, state_ff == ST_GCD, (ga_ff != '0) && (gb_ff != '0))
   `LIRC_ASSERT_NOW(a_idle_drained, (state_ff == ST_IDLE) && (primed_ff == PRIMED_FULL), out_pos_ff > in_pos_ff)
   `LIRC_ASSERT_NEXT(a_last_ends_burst, rsp_load && last_bit, (out_pos_ff > in_pos_ff) || (count_ff == lirc_pkg::RESULT_LIMIT_C))

endmodule
